/* hw/rtl/gwpi_pkg.sv */
`default_nettype none
package gwpi_pkg;

	localparam int MAX_MEASURES = 256;
	localparam int ADDR_W       = $clog2(MAX_MEASURES);
	localparam int CNT_W        = $clog2(MAX_MEASURES + 1);
	localparam int EXP_DEPTH    = 1024;
	localparam int IDX_W        = $clog2(EXP_DEPTH);
	localparam int TAYLOR_TERMS = 24;
	localparam int R2_W         = 50;
	// weight is nonzero only while r2/4 stays below 16.0, i.e. r2 < 2^38 in Q.32
	localparam int R2_CUT       = 38;
	localparam int SLOT_W       = 8;
	localparam int POS_W        = 32;
	localparam int SCALE_W      = 24;
	localparam int VAL_W        = 32;
	localparam int W_W          = 16;
	localparam int WSUM_W       = W_W + ADDR_W + 1;
	localparam int DATA_IN_W    = 216;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t                       op;
		logic [SLOT_W-1:0]         slot;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic [SCALE_W-1:0]        scale_x;
		logic [SCALE_W-1:0]        scale_y;
		logic [SCALE_W-1:0]        scale_z;
		logic signed [VAL_W-1:0]   sample_value;
		logic                      use_flag;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic [SCALE_W-1:0]        scale_x;
		logic [SCALE_W-1:0]        scale_y;
		logic [SCALE_W-1:0]        scale_z;
		logic signed [VAL_W-1:0]   value;
		logic                      enabled;
	} meas_t;

	typedef struct packed {
		logic start;
		logic neg;
	} div_ctl_t;

	typedef logic [W_W-1:0] rom_t [EXP_DEPTH];

	function automatic logic [63:0] div_small(logic [63:0] x, int n);
		case (n)
			1: return x;        2: return x / 2;    3: return x / 3;    4: return x / 4;
			5: return x / 5;    6: return x / 6;    7: return x / 7;    8: return x / 8;
			9: return x / 9;    10: return x / 10;  11: return x / 11;  12: return x / 12;
			13: return x / 13;  14: return x / 14;  15: return x / 15;  16: return x / 16;
			17: return x / 17;  18: return x / 18;  19: return x / 19;  20: return x / 20;
			21: return x / 21;  22: return x / 22;  23: return x / 23;  24: return x / 24;
			default: return x;
		endcase
	endfunction

	// exp(-16k/depth): taylor series for exp(-k/depth) in Q.40, then squared four times
	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] t;
		logic [63:0] w;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			term = 64'd1 << 40;
			sum  = term;
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				term = div_small((term * 64'(k)) >> IDX_W, n);
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			t = sum >> 10;
			for (int i = 0; i < 4; i++) begin
				t = (t * t) >> 30;
			end
			w = (t + (64'd1 << 13)) >> 14;
			if (w > 64'd65535) begin
				w = 64'd65535;
			end
			r[k] = w[W_W-1:0];
		end
		return r;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

endpackage
`default_nettype wire

/* hw/rtl/gwpi_front.sv */
`default_nettype none
module gwpi_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [gwpi_pkg::DATA_IN_W-1:0]  s_tdata,
	input  wire logic                            s_tuser,
	output logic                                 item_valid,
	output gwpi_pkg::item_t                      item,
	input  wire logic                            item_pop
);

	gwpi_pkg::item_t in_item;
	gwpi_pkg::item_t buf_q [2];
	logic [1:0]      count_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic            push;
	logic            pop;

	always_comb begin
		in_item.op           = s_tuser ? gwpi_pkg::OP_QUERY : gwpi_pkg::OP_LOAD;
		in_item.slot         = s_tdata[7:0];
		in_item.pos_x        = s_tdata[39:8];
		in_item.pos_y        = s_tdata[71:40];
		in_item.pos_z        = s_tdata[103:72];
		in_item.scale_x      = s_tdata[127:104];
		in_item.scale_y      = s_tdata[151:128];
		in_item.scale_z      = s_tdata[175:152];
		in_item.sample_value = s_tdata[207:176];
		in_item.use_flag     = s_tdata[208];
	end

	assign s_tready   = (count_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (count_q != 2'd0);
	assign pop        = item_pop && item_valid;
	assign item       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/gwpi_div.sv */
`default_nettype none
module gwpi_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire gwpi_pkg::div_ctl_t             ctl,
	input  wire logic [63:0]                    dividend,
	input  wire logic [gwpi_pkg::WSUM_W-1:0]    divisor,
	output logic                                done,
	output logic [31:0]                         quot
);

	localparam int DW = gwpi_pkg::WSUM_W;

	logic [63:0]   dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          neg_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [63:0]   q_signed;

	assign trial = {rem_q, dvd_q[63]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= ctl.neg;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// truncation toward zero: divide magnitudes, then restore sign
	assign q_signed = neg_q ? (64'd0 - dvd_q) : dvd_q;
	assign quot     = q_signed[31:0];
	assign done     = done_q;

endmodule
`default_nettype wire

/* hw/rtl/gwpi_back.sv */
`default_nettype none
module gwpi_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [gwpi_pkg::CNT_W-1:0]   n_eff,
	input  wire logic                         item_valid,
	input  wire gwpi_pkg::item_t              item,
	output logic                              item_pop,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [31:0]                       m_tdata,
	output logic                              m_tuser
);

	localparam int AW = gwpi_pkg::ADDR_W;
	localparam int CW = gwpi_pkg::CNT_W;

	gwpi_pkg::state_t state_q, state_d;

	gwpi_pkg::meas_t mem [gwpi_pkg::MAX_MEASURES];
	gwpi_pkg::meas_t rd_s1;

	logic [CW-1:0] cnt_q;
	logic          issue;
	logic          load_we;
	logic          start_query;
	logic          pipe_busy;
	logic          out_free;
	logic          out_load;
	logic          div_done;
	logic [31:0]   div_quot;
	logic [63:0]   div_mag;
	gwpi_pkg::div_ctl_t div_ctl;

	logic signed [31:0] qx_q, qy_q, qz_q;

	logic v1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7;

	logic [32:0] ax_s2, ay_s2, az_s2;
	logic [23:0] sx_s2, sy_s2, sz_s2;
	logic signed [31:0] val_s2, val_s3, val_s4, val_s5, val_s6;
	logic en_s2, en_s3, en_s4, en_s5;

	logic [23:0] tx_s3, ty_s3, tz_s3;
	logic [47:0] px_s4, py_s4, pz_s4;
	logic [gwpi_pkg::IDX_W-1:0] idx_s5;
	logic hit_s5;
	logic [gwpi_pkg::W_W-1:0] w_s6;
	logic signed [47:0] prod_s7;

	logic [gwpi_pkg::WSUM_W-1:0] wsum_q;
	logic signed [63:0]          vsum_q;

	logic signed [32:0] dx, dy, dz;
	logic [56:0] mx, my, mz;
	logic [gwpi_pkg::R2_W-1:0] r2;
	logic signed [47:0] prod;
	logic [31:0] res_q;
	logic        had_q;
	logic [31:0] mdata_q;
	logic        muser_q;
	logic        mvalid_q;

	function automatic logic [32:0] abs33(logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [23:0] sat24(logic [56:0] v);
		return (v[56:40] != '0) ? 24'hFFFFFF : v[39:16];
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gwpi_pkg::ST_IDLE: begin
				if (item_valid && item.op == gwpi_pkg::OP_QUERY) begin
					state_d = gwpi_pkg::ST_SWEEP;
				end
			end
			gwpi_pkg::ST_SWEEP: begin
				if (cnt_q >= n_eff) begin
					state_d = gwpi_pkg::ST_DRAIN;
				end
			end
			gwpi_pkg::ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = (wsum_q == '0) ? gwpi_pkg::ST_OUT : gwpi_pkg::ST_DIV;
				end
			end
			gwpi_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = gwpi_pkg::ST_OUT;
				end
			end
			gwpi_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = gwpi_pkg::ST_IDLE;
				end
			end
			default: state_d = gwpi_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_pop      = 1'b0;
		load_we       = 1'b0;
		start_query   = 1'b0;
		issue         = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.neg   = vsum_q[63];
		out_load      = 1'b0;
		case (state_q)
			gwpi_pkg::ST_IDLE: begin
				item_pop    = item_valid;
				load_we     = item_valid && (item.op == gwpi_pkg::OP_LOAD)
					&& (32'(item.slot) < gwpi_pkg::MAX_MEASURES);
				start_query = item_valid && (item.op == gwpi_pkg::OP_QUERY);
			end
			gwpi_pkg::ST_SWEEP: issue = (cnt_q < n_eff);
			gwpi_pkg::ST_DRAIN: div_ctl.start = !pipe_busy && (wsum_q != '0);
			gwpi_pkg::ST_OUT:   out_load = out_free;
			default: ;
		endcase
	end

	assign pipe_busy = v1 | v2_s2 | v3_s3 | v4_s4 | v5_s5 | v6_s6 | v7_s7;
	assign out_free  = !mvalid_q || m_tready;
	assign div_mag   = vsum_q[63] ? (64'd0 - 64'(vsum_q)) : 64'(vsum_q);

	gwpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_mag),
		.divisor  (wsum_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[item.slot[AW-1:0]] <= '{pos_x: item.pos_x, pos_y: item.pos_y,
				pos_z: item.pos_z, scale_x: item.scale_x, scale_y: item.scale_y,
				scale_z: item.scale_z, value: item.sample_value, enabled: item.use_flag};
		end
		rd_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_comb begin
		dx   = 33'(qx_q) - 33'(rd_s1.pos_x);
		dy   = 33'(qy_q) - 33'(rd_s1.pos_y);
		dz   = 33'(qz_q) - 33'(rd_s1.pos_z);
		mx   = 57'(ax_s2) * 57'(sx_s2);
		my   = 57'(ay_s2) * 57'(sy_s2);
		mz   = 57'(az_s2) * 57'(sz_s2);
		r2   = gwpi_pkg::R2_W'(px_s4) + gwpi_pkg::R2_W'(py_s4) + gwpi_pkg::R2_W'(pz_s4);
		prod = 48'(val_s6) * $signed({32'd0, w_s6});
	end

	// datapath stages, one slot per cycle
	always_ff @(posedge clk) begin
		if (start_query) begin
			qx_q <= item.pos_x;
			qy_q <= item.pos_y;
			qz_q <= item.pos_z;
		end
		ax_s2  <= abs33(dx);
		ay_s2  <= abs33(dy);
		az_s2  <= abs33(dz);
		sx_s2  <= rd_s1.scale_x;
		sy_s2  <= rd_s1.scale_y;
		sz_s2  <= rd_s1.scale_z;
		val_s2 <= rd_s1.value;
		en_s2  <= rd_s1.enabled;

		tx_s3  <= sat24(mx);
		ty_s3  <= sat24(my);
		tz_s3  <= sat24(mz);
		val_s3 <= val_s2;
		en_s3  <= en_s2;

		px_s4  <= 48'(tx_s3) * 48'(tx_s3);
		py_s4  <= 48'(ty_s3) * 48'(ty_s3);
		pz_s4  <= 48'(tz_s3) * 48'(tz_s3);
		val_s4 <= val_s3;
		en_s4  <= en_s3;

		hit_s5 <= (r2[gwpi_pkg::R2_W-1:gwpi_pkg::R2_CUT] == '0);
		idx_s5 <= r2[gwpi_pkg::R2_CUT-1 -: gwpi_pkg::IDX_W];
		val_s5 <= val_s4;
		en_s5  <= en_s4;

		w_s6   <= (hit_s5 && en_s5) ? gwpi_pkg::EXP_ROM[idx_s5] : '0;
		val_s6 <= val_s5;

		prod_s7 <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gwpi_pkg::ST_IDLE;
			cnt_q    <= '0;
			v1       <= 1'b0;
			v2_s2    <= 1'b0;
			v3_s3    <= 1'b0;
			v4_s4    <= 1'b0;
			v5_s5    <= 1'b0;
			v6_s6    <= 1'b0;
			v7_s7    <= 1'b0;
			wsum_q   <= '0;
			vsum_q   <= '0;
			res_q    <= '0;
			had_q    <= 1'b0;
			mvalid_q <= 1'b0;
			mdata_q  <= '0;
			muser_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			v1      <= issue;
			v2_s2   <= v1;
			v3_s3   <= v2_s2;
			v4_s4   <= v3_s3;
			v5_s5   <= v4_s4;
			v6_s6   <= v5_s5;
			v7_s7   <= v6_s6;
			if (start_query) begin
				cnt_q  <= '0;
				wsum_q <= '0;
				vsum_q <= '0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (v6_s6) begin
					wsum_q <= wsum_q + gwpi_pkg::WSUM_W'(w_s6);
				end
				if (v7_s7) begin
					vsum_q <= vsum_q + 64'(prod_s7);
				end
			end
			if (state_q == gwpi_pkg::ST_DRAIN && !pipe_busy && wsum_q == '0) begin
				res_q <= '0;
				had_q <= 1'b0;
			end else if (div_done) begin
				res_q <= div_quot;
				had_q <= 1'b1;
			end
			if (out_load) begin
				mvalid_q <= 1'b1;
				mdata_q  <= res_q;
				muser_q  <= had_q;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;

endmodule
`default_nettype wire

/* hw/rtl/gaussian_weighted_point_interpolator_core.sv */
`default_nettype none
// load items: taken through a two-word input queue and written to the slot store back to back
// query items: popped from the queue, then a sweep over n slots (one slot per cycle) and a
// pipeline drain, a pass through the bit-serial divider and a load of the output register
// once it is free, with n = active count; no divider pass when no weight is found
// queries are handled one at a time; the queue takes up to two words while the engine is busy
// reset: asynchronous, active low; clears queue, sequencer, count; slot store is not reset
module gaussian_weighted_point_interpolator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// slot, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, sample_value, use_flag
	input  wire logic [gwpi_pkg::DATA_IN_W-1:0]  s_tdata,
	// kind
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// result_value
	output logic [31:0]                          m_tdata,
	// had_weight
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [8:0]                      cfg_data
);

	logic [8:0]                     measure_count_q;
	logic [gwpi_pkg::CNT_W-1:0]     n_eff;
	logic                           item_valid;
	logic                           item_pop;
	gwpi_pkg::item_t                item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			measure_count_q <= cfg_data;
		end
	end

	assign n_eff = (32'(measure_count_q) > gwpi_pkg::MAX_MEASURES)
		? gwpi_pkg::CNT_W'(gwpi_pkg::MAX_MEASURES) : gwpi_pkg::CNT_W'(measure_count_q);

	gwpi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	gwpi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.n_eff      (n_eff),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire
